>>> rtl/sts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and small lookup functions for the sphere
// triangle subdivider. No dependencies.
package sts_pkg;

  // Coordinate format: signed, COORD_BITS wide, COORD_BITS-2 fraction bits
  localparam int COORD_BITS      = 16;
  localparam int MAX_LEVELS_DEF  = 4;
  localparam int LEVEL_W         = 3;
  localparam int SLOTS           = 6;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [2:0][COORD_BITS-1:0]   vertex_t;
  typedef logic [LEVEL_W-1:0]           level_t;

  // Top level sequencer
  typedef enum logic [3:0] {
    T_IDLE, T_LOAD, T_NODE, T_MRDP, T_MRDQ, T_MSUM, T_NORM,
    T_CPRD, T_CPWR, T_ERD, T_ECAP, T_OUT, T_UP, T_UP2
  } tri_state_t;

  // Normalizer sequencer
  typedef enum logic [3:0] {
    N_IDLE, N_SQ, N_ACC, N_CHK, N_X2, N_X2C, N_DD, N_DS, N_CMP, N_PUT, N_DONE
  } norm_state_t;

  // Handshake between sequencer and normalizer
  typedef struct packed {
    logic    start;
    vertex_t vin;
  } norm_req_t;

  typedef struct packed {
    logic    done;
    vertex_t vout;
  } norm_rsp_t;

  // Slot of the parent that feeds corner i of child c
  function automatic logic [2:0] child_pick(input logic [1:0] c, input logic [1:0] i);
    logic [2:0] s;
    s = 3'd0;
    case ({c, i})
      4'b00_00: s = 3'd0;
      4'b00_01: s = 3'd4;
      4'b00_10: s = 3'd3;
      4'b01_00: s = 3'd4;
      4'b01_01: s = 3'd1;
      4'b01_10: s = 3'd5;
      4'b10_00: s = 3'd3;
      4'b10_01: s = 3'd4;
      4'b10_10: s = 3'd5;
      4'b11_00: s = 3'd3;
      4'b11_01: s = 3'd5;
      4'b11_10: s = 3'd2;
      default:  s = 3'd0;
    endcase
    return s;
  endfunction

  // Edge endpoints: a = (0,2), b = (0,1), c = (1,2)
  function automatic logic [2:0] mid_p(input logic [1:0] mi);
    logic [2:0] s;
    s = (mi == 2'd2) ? 3'd1 : 3'd0;
    return s;
  endfunction

  function automatic logic [2:0] mid_q(input logic [1:0] mi);
    logic [2:0] s;
    s = (mi == 2'd1) ? 3'd1 : 3'd2;
    return s;
  endfunction

  // Midpoint, rounded toward minus infinity
  function automatic vertex_t mid_of(input vertex_t p, input vertex_t q);
    vertex_t               m;
    logic [COORD_BITS:0]   sum;
    for (int j = 0; j < 3; j++) begin
      sum  = {p[j][COORD_BITS-1], p[j]} + {q[j][COORD_BITS-1], q[j]};
      m[j] = sum[COORD_BITS:1];
    end
    return m;
  endfunction

endpackage

>>> rtl/sts_in_if.sv
`timescale 1ns / 1ps
// Seed triangle channel: valid/ready plus nine coordinates.
// Depends on sts_pkg.
interface sts_in_if;
  logic              valid;
  logic              ready;
  sts_pkg::coord_t   v0_x, v0_y, v0_z;
  sts_pkg::coord_t   v1_x, v1_y, v1_z;
  sts_pkg::coord_t   v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, output ready);
endinterface

>>> rtl/sts_out_if.sv
`timescale 1ns / 1ps
// Result triangle channel: valid/ready, nine coordinates, last flag.
// Depends on sts_pkg.
interface sts_out_if;
  logic              valid;
  logic              ready;
  sts_pkg::coord_t   out0_x, out0_y, out0_z;
  sts_pkg::coord_t   out1_x, out1_y, out1_z;
  sts_pkg::coord_t   out2_x, out2_y, out2_z;
  logic              last_triangle;

  modport source (output valid, out0_x, out0_y, out0_z, out1_x, out1_y, out1_z,
                  out2_x, out2_y, out2_z, last_triangle, input ready);
  modport sink   (input valid, out0_x, out0_y, out0_z, out1_x, out1_y, out1_z,
                  out2_x, out2_y, out2_z, last_triangle, output ready);
endinterface

>>> rtl/sts_norm.sv
`timescale 1ns / 1ps
// Midpoint projection onto the unit sphere, one result bit per two passes
// through a shared 32x32 multiplier. Depends on sts_pkg.
module sts_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  sts_pkg::norm_req_t  req,
  output sts_pkg::norm_rsp_t  rsp
);
  localparam int CB = sts_pkg::COORD_BITS;
  localparam int NB = CB - 1;
  localparam int BW = $clog2(NB);
  localparam int MW = 2 * CB;
  localparam int PW = 4 * CB;

  sts_pkg::norm_state_t state_r, state_nxt;
  sts_pkg::vertex_t     m_r, m_nxt, v_r, v_nxt;
  logic [MW-1:0]        s_r, s_nxt, x2_r, x2_nxt;
  logic [NB-1:0]        n_r, n_nxt;
  logic [BW-1:0]        b_r, b_nxt;
  logic [1:0]           j_r, j_nxt;
  logic [PW-1:0]        prod_r;
  logic [MW-1:0]        mul_a, mul_b;
  logic [CB-1:0]        mag, dval, nq;
  logic [NB-1:0]        trial;
  logic [PW-1:0]        rhs;

  // Operand shaping
  always_comb begin
    mag   = m_r[j_r][CB-1] ? (~m_r[j_r] + CB'(1)) : m_r[j_r];
    trial = n_r | (NB'(1) << b_r);
    dval  = {trial, 1'b0} - CB'(1);
    rhs   = PW'({x2_r, {(MW-2){1'b0}}});
    nq    = {1'b0, n_r};
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    v_nxt     = v_r;
    s_nxt     = s_r;
    x2_nxt    = x2_r;
    n_nxt     = n_r;
    b_nxt     = b_r;
    j_nxt     = j_r;
    mul_a     = MW'(mag);
    mul_b     = MW'(mag);
    rsp.done  = 1'b0;
    rsp.vout  = v_r;
    unique case (state_r)
      sts_pkg::N_IDLE: begin
        if (req.start) begin
          m_nxt     = req.vin;
          v_nxt     = req.vin;
          s_nxt     = '0;
          j_nxt     = 2'd0;
          state_nxt = sts_pkg::N_SQ;
        end
      end
      sts_pkg::N_SQ: state_nxt = sts_pkg::N_ACC;
      sts_pkg::N_ACC: begin
        s_nxt = s_r + prod_r[MW-1:0];
        if (j_r == 2'd2) begin
          j_nxt     = 2'd0;
          state_nxt = sts_pkg::N_CHK;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = sts_pkg::N_SQ;
        end
      end
      // zero-length midpoint stays as it is
      sts_pkg::N_CHK: state_nxt = (s_r == '0) ? sts_pkg::N_DONE : sts_pkg::N_X2;
      sts_pkg::N_X2:  state_nxt = sts_pkg::N_X2C;
      sts_pkg::N_X2C: begin
        x2_nxt    = prod_r[MW-1:0];
        n_nxt     = '0;
        b_nxt     = BW'(NB - 1);
        state_nxt = sts_pkg::N_DD;
      end
      sts_pkg::N_DD: begin
        mul_a     = MW'(dval);
        mul_b     = MW'(dval);
        state_nxt = sts_pkg::N_DS;
      end
      sts_pkg::N_DS: begin
        mul_a     = prod_r[MW-1:0];
        mul_b     = s_r;
        state_nxt = sts_pkg::N_CMP;
      end
      // keep the bit while (2n-1)^2 * S <= x^2 * 2^(2CB-2)
      sts_pkg::N_CMP: begin
        if (prod_r <= rhs) n_nxt = trial;
        if (b_r == '0) state_nxt = sts_pkg::N_PUT;
        else begin
          b_nxt     = b_r - BW'(1);
          state_nxt = sts_pkg::N_DD;
        end
      end
      sts_pkg::N_PUT: begin
        v_nxt[j_r] = m_r[j_r][CB-1] ? (~nq + CB'(1)) : nq;
        if (j_r == 2'd2) state_nxt = sts_pkg::N_DONE;
        else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = sts_pkg::N_X2;
        end
      end
      sts_pkg::N_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = sts_pkg::N_IDLE;
      end
      default: state_nxt = sts_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sts_pkg::N_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    m_r  <= m_nxt;
    v_r  <= v_nxt;
    s_r  <= s_nxt;
    x2_r <= x2_nxt;
    n_r  <= n_nxt;
    b_r  <= b_nxt;
    j_r  <= j_nxt;
  end

endmodule

>>> rtl/sphere_triangle_subdivider.sv
`timescale 1ns / 1ps
// Sphere triangle subdivider, top level: depth-first walk over a vertex
// stack memory. Depends on sts_pkg, sts_in_if, sts_out_if, sts_norm.
//
// Usage:
//   in_tri  : one seed triangle per transaction (valid/ready). Ready is high
//             only while the block is idle; a seed is taken whole.
//   out_tri : 4^(levels-1) result triangles per seed, depth-first order,
//             last_triangle set on the final one. Held until accepted; a
//             stalled receiver simply stalls the walk.
//   cfg_we/cfg_wdata : subdivision level, written while idle. 0 acts as 1,
//             values above MAX_LEVELS act as MAX_LEVELS. Reset value 1.
// Work: each midpoint goes through the normalizer, which spends two passes of
//   its one 32x32 multiplier per result bit (15 bits per coordinate, three
//   coordinates). A node adds 3 midpoints; each result also waits for ready.
// Reset: synchronous, active low; the sequencer returns to idle, level is 1.
//   The vertex stack needs no clearing, it is written before it is read.
module sphere_triangle_subdivider #(
  parameter int MAX_LEVELS = sts_pkg::MAX_LEVELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  sts_in_if.sink                  in_tri,
  sts_out_if.source               out_tri,
  input  logic                    cfg_we,
  input  sts_pkg::level_t         cfg_wdata
);
  localparam int DEPTH = MAX_LEVELS * sts_pkg::SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int KW    = (MAX_LEVELS > 1) ? 2 * (MAX_LEVELS - 1) : 1;

  sts_pkg::tri_state_t state_r, state_nxt;
  sts_pkg::level_t     lvl_r;
  sts_pkg::vertex_t    seed_r [3];
  sts_pkg::vertex_t    seed_nxt [3];
  sts_pkg::vertex_t    p_r, p_nxt;
  sts_pkg::vertex_t    ov_r [3];
  sts_pkg::vertex_t    ov_nxt [3];
  logic                last_r, last_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [DW-1:0]       d_r, d_nxt, leafd_r, leafd_nxt, leafd_in;
  logic [1:0]          cidx_r [MAX_LEVELS];
  logic [1:0]          cidx_wdata;
  logic                cidx_we;
  logic [1:0]          i_r, i_nxt, mi_r, mi_nxt;
  logic [KW-1:0]       k_r, k_nxt, kmask;
  sts_pkg::level_t     lv_eff;

  // Vertex stack memory
  sts_pkg::vertex_t    mem [DEPTH];
  sts_pkg::vertex_t    rdata_r, wdata;
  logic [AW-1:0]       raddr, waddr;
  logic                we;

  sts_pkg::norm_req_t  nreq;
  sts_pkg::norm_rsp_t  nrsp;

  function automatic logic [AW-1:0] addr_of(input logic [DW:0] d, input logic [2:0] slot);
    logic [AW-1:0] a;
    a = AW'((AW'(d) << 2) + (AW'(d) << 1) + AW'(slot));
    return a;
  endfunction

  sts_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Effective level and leaf depth
  always_comb begin
    if (lvl_r == '0)                              lv_eff = sts_pkg::level_t'(1);
    else if (lvl_r > sts_pkg::level_t'(MAX_LEVELS)) lv_eff = sts_pkg::level_t'(MAX_LEVELS);
    else                                          lv_eff = lvl_r;
    leafd_in = DW'(lv_eff - sts_pkg::level_t'(1));
    kmask    = ~(~KW'(0) << {leafd_r, 1'b0});
  end

  // Output channel
  assign out_tri.valid         = ovalid_r;
  assign out_tri.out0_x        = ov_r[0][0];
  assign out_tri.out0_y        = ov_r[0][1];
  assign out_tri.out0_z        = ov_r[0][2];
  assign out_tri.out1_x        = ov_r[1][0];
  assign out_tri.out1_y        = ov_r[1][1];
  assign out_tri.out1_z        = ov_r[1][2];
  assign out_tri.out2_x        = ov_r[2][0];
  assign out_tri.out2_y        = ov_r[2][1];
  assign out_tri.out2_z        = ov_r[2][2];
  assign out_tri.last_triangle = last_r;
  assign in_tri.ready          = (state_r == sts_pkg::T_IDLE);

  // Walk sequencer
  always_comb begin
    state_nxt  = state_r;
    seed_nxt   = seed_r;
    p_nxt      = p_r;
    ov_nxt     = ov_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    d_nxt      = d_r;
    leafd_nxt  = leafd_r;
    i_nxt      = i_r;
    mi_nxt     = mi_r;
    k_nxt      = k_r;
    cidx_we    = 1'b0;
    cidx_wdata = 2'd0;
    raddr      = '0;
    waddr      = '0;
    wdata      = nrsp.vout;
    we         = 1'b0;
    nreq.start = 1'b0;
    nreq.vin   = sts_pkg::mid_of(p_r, rdata_r);
    unique case (state_r)
      sts_pkg::T_IDLE: begin
        if (in_tri.valid) begin
          seed_nxt[0] = {in_tri.v0_z, in_tri.v0_y, in_tri.v0_x};
          seed_nxt[1] = {in_tri.v1_z, in_tri.v1_y, in_tri.v1_x};
          seed_nxt[2] = {in_tri.v2_z, in_tri.v2_y, in_tri.v2_x};
          leafd_nxt   = leafd_in;
          d_nxt       = '0;
          i_nxt       = 2'd0;
          k_nxt       = '0;
          state_nxt   = sts_pkg::T_LOAD;
        end
      end
      sts_pkg::T_LOAD: begin
        we    = 1'b1;
        waddr = addr_of('0, {1'b0, i_r});
        wdata = seed_r[i_r];
        if (i_r == 2'd2) begin
          i_nxt     = 2'd0;
          state_nxt = sts_pkg::T_NODE;
        end else i_nxt = i_r + 2'd1;
      end
      sts_pkg::T_NODE: begin
        i_nxt = 2'd0;
        if (d_r == leafd_r) state_nxt = sts_pkg::T_ERD;
        else begin
          mi_nxt     = 2'd0;
          cidx_we    = 1'b1;
          cidx_wdata = 2'd0;
          state_nxt  = sts_pkg::T_MRDP;
        end
      end
      sts_pkg::T_MRDP: begin
        raddr     = addr_of({1'b0, d_r}, sts_pkg::mid_p(mi_r));
        state_nxt = sts_pkg::T_MRDQ;
      end
      sts_pkg::T_MRDQ: begin
        raddr     = addr_of({1'b0, d_r}, sts_pkg::mid_q(mi_r));
        p_nxt     = rdata_r;
        state_nxt = sts_pkg::T_MSUM;
      end
      sts_pkg::T_MSUM: begin
        nreq.start = 1'b1;
        state_nxt  = sts_pkg::T_NORM;
      end
      sts_pkg::T_NORM: begin
        if (nrsp.done) begin
          we    = 1'b1;
          waddr = addr_of({1'b0, d_r}, 3'd3 + {1'b0, mi_r});
          if (mi_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = sts_pkg::T_CPRD;
          end else begin
            mi_nxt    = mi_r + 2'd1;
            state_nxt = sts_pkg::T_MRDP;
          end
        end
      end
      // copy the chosen child's corners one level down
      sts_pkg::T_CPRD: begin
        raddr     = addr_of({1'b0, d_r}, sts_pkg::child_pick(cidx_r[d_r], i_r));
        state_nxt = sts_pkg::T_CPWR;
      end
      sts_pkg::T_CPWR: begin
        we    = 1'b1;
        waddr = addr_of({1'b0, d_r} + (DW + 1)'(1), {1'b0, i_r});
        wdata = rdata_r;
        if (i_r == 2'd2) begin
          i_nxt     = 2'd0;
          d_nxt     = d_r + DW'(1);
          state_nxt = sts_pkg::T_NODE;
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = sts_pkg::T_CPRD;
        end
      end
      sts_pkg::T_ERD: begin
        raddr     = addr_of({1'b0, d_r}, {1'b0, i_r});
        state_nxt = sts_pkg::T_ECAP;
      end
      sts_pkg::T_ECAP: begin
        ov_nxt[i_r] = rdata_r;
        if (i_r == 2'd2) begin
          last_nxt   = ((k_r & kmask) == kmask);
          ovalid_nxt = 1'b1;
          state_nxt  = sts_pkg::T_OUT;
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = sts_pkg::T_ERD;
        end
      end
      sts_pkg::T_OUT: begin
        if (out_tri.ready) begin
          ovalid_nxt = 1'b0;
          k_nxt      = k_r + KW'(1);
          state_nxt  = sts_pkg::T_UP;
        end
      end
      // climb until a level still has a child to visit, or go idle from the top
      sts_pkg::T_UP: begin
        if (d_r == '0) state_nxt = sts_pkg::T_IDLE;
        else begin
          d_nxt     = d_r - DW'(1);
          state_nxt = sts_pkg::T_UP2;
        end
      end
      sts_pkg::T_UP2: begin
        if (cidx_r[d_r] == 2'd3) state_nxt = sts_pkg::T_UP;
        else begin
          cidx_we    = 1'b1;
          cidx_wdata = cidx_r[d_r] + 2'd1;
          i_nxt      = 2'd0;
          state_nxt  = sts_pkg::T_CPRD;
        end
      end
      default: state_nxt = sts_pkg::T_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sts_pkg::T_IDLE;
      lvl_r    <= sts_pkg::level_t'(1);
      ovalid_r <= 1'b0;
      d_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      d_r      <= d_nxt;
      if (cfg_we) lvl_r <= cfg_wdata;
    end
  end

  // Payload and walk bookkeeping
  always_ff @(posedge clk) begin
    seed_r  <= seed_nxt;
    p_r     <= p_nxt;
    ov_r    <= ov_nxt;
    last_r  <= last_nxt;
    leafd_r <= leafd_nxt;
    i_r     <= i_nxt;
    mi_r    <= mi_nxt;
    k_r     <= k_nxt;
    if (cidx_we) cidx_r[d_r] <= cidx_wdata;
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sts_pkg::T_IDLE |-> d_r <= leafd_r)
    else $error("walk depth beyond leaf depth");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    nrsp.done |-> state_r == sts_pkg::T_NORM)
    else $error("normalizer finished outside its wait state");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> waddr < AW'(DEPTH - 1) || waddr == AW'(DEPTH - 1))
    else $error("vertex stack write out of range");

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == sts_pkg::T_OUT)
    else $error("result shown outside output state");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && out_tri.ready && last_r |=> state_r == sts_pkg::T_UP && k_r == '0
      || state_r == sts_pkg::T_UP && d_r != '0 || state_r == sts_pkg::T_UP)
    else $error("last result not followed by the climb");

endmodule
